### src/mor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mor_pkg
// Shared types and constants for the fewest-operations-to-one calculator.
// ----------------------------------------------------------------------------
package mor_pkg;

  localparam int VAL_W  = 16;   // chain value / target width
  localparam int STEP_W = 6;    // step count width
  localparam int CNT_W  = 6;    // index of a word within one chain

  localparam logic [STEP_W-1:0] STEP_MAX   = 6'd63;
  localparam logic [CNT_W-1:0]  CHAIN_LAST = 6'd63;  // index of the 64th word

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_RD3,
    ST_FILL_RD2,
    ST_FILL_WR,
    ST_TR_RD,
    ST_TR_CAP,
    ST_EMIT
  } state_t;

  // chosen operation for a table entry
  typedef enum logic [1:0] {
    PICK_DIV3,
    PICK_DIV2,
    PICK_DEC
  } pick_t;

  // candidate step counts for one entry
  typedef struct packed {
    logic              div3_ok;
    logic              div2_ok;
    logic [STEP_W-1:0] step_div3;
    logic [STEP_W-1:0] step_div2;
    logic [STEP_W-1:0] step_dec;
  } cand_t;

  // winning candidate
  typedef struct packed {
    logic [STEP_W-1:0] step;
    pick_t             pick;
  } best_t;

endpackage

### src/mor_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mor_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mor_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/mor_best.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mor_best
// Picks the cheapest predecessor for one entry: divide by 3, divide by 2,
// subtract 1, in that priority on ties.
// ----------------------------------------------------------------------------
module mor_best (
  input  mor_pkg::cand_t cand,
  output mor_pkg::best_t best
);
  import mor_pkg::*;

  // step count plus one, saturated
  function automatic logic [STEP_W-1:0] sat_inc(input logic [STEP_W-1:0] s);
    logic [STEP_W:0] sum;
    sum = {1'b0, s} + {{STEP_W{1'b0}}, 1'b1};
    return (sum > {1'b0, STEP_MAX}) ? STEP_MAX : sum[STEP_W-1:0];
  endfunction

  logic [STEP_W-1:0] c3;
  logic [STEP_W-1:0] c2;
  logic [STEP_W-1:0] c1;
  logic [STEP_W:0]   best_cost;
  pick_t             best_pick;

  assign c3 = sat_inc(cand.step_div3);
  assign c2 = sat_inc(cand.step_div2);
  assign c1 = sat_inc(cand.step_dec);

  // strict-less compare keeps the earlier candidate on ties
  always_comb begin
    best_cost = {1'b1, {STEP_W{1'b0}}};
    best_pick = PICK_DEC;
    if (cand.div3_ok && ({1'b0, c3} < best_cost)) begin
      best_cost = {1'b0, c3};
      best_pick = PICK_DIV3;
    end
    if (cand.div2_ok && ({1'b0, c2} < best_cost)) begin
      best_cost = {1'b0, c2};
      best_pick = PICK_DIV2;
    end
    if ({1'b0, c1} < best_cost) begin
      best_cost = {1'b0, c1};
      best_pick = PICK_DEC;
    end
  end

  assign best.step = best_cost[STEP_W-1:0];
  assign best.pick = best_pick;

endmodule

### src/min_ops_reduce_to_one_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_ops_reduce_to_one_dp
// Fewest-operations chain to one (divide by 3, divide by 2, subtract 1).
// Step and predecessor tables live in one RAM, filled bottom-up on demand
// and kept across requests; the chain is then traced out one word per value.
// ----------------------------------------------------------------------------
//   channel | ports                                          | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid, in_stall, in_target                   | in
//   out     | out_valid, out_stall, out_chain_value,          | out
//           | out_total_steps, out_error, out_last            |
//
// Steps: each newly filled table entry takes two RAM reads and one write;
//   each chain word takes a read, a capture and an emit, plus any output
//   stall; an error word is emitted straight from idle.
// One request at a time: in_stall is high from acceptance to the last word.
// Reset clears the sequencer, the fill pointer and the fill state only; the
//   RAM is not cleared, entry one's step is supplied by logic, not memory.
// ----------------------------------------------------------------------------
module min_ops_reduce_to_one_dp #(
  parameter int MAX_VALUE = 65536
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mor_pkg::VAL_W-1:0]        in_target,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [mor_pkg::VAL_W-1:0]        out_chain_value,
  output logic [mor_pkg::STEP_W-1:0]       out_total_steps,
  output logic                             out_error,
  output logic                             out_last
);
  import mor_pkg::*;

  localparam int AW = $clog2(MAX_VALUE);          // table address width
  localparam int NW = $clog2(MAX_VALUE + 1);      // fill pointer width
  localparam int CW = (NW > VAL_W) ? NW : VAL_W;  // compare width
  localparam int EW = STEP_W + AW;                // RAM word width

  // sequencer
  state_t state_r, state_nxt;

  // datapath registers
  logic [VAL_W-1:0]  target_r,  target_nxt;
  logic [AW-1:0]     cur_r,     cur_nxt;
  logic [CNT_W-1:0]  cnt_r,     cnt_nxt;
  logic              first_r,   first_nxt;
  logic [STEP_W-1:0] steps_r,   steps_nxt;
  logic [NW-1:0]     next_v_r,  next_v_nxt;  // first unfilled entry
  logic [AW-1:0]     q3_r,      q3_nxt;      // next_v / 3
  logic [1:0]        r3_r,      r3_nxt;      // next_v % 3
  logic [STEP_W-1:0] prev_step_r, prev_step_nxt;  // step of next_v - 1
  logic [STEP_W-1:0] s3_r,      s3_nxt;
  logic              rd_one_r;

  // output word registers
  logic [VAL_W-1:0]  oval_r,   oval_nxt;
  logic [STEP_W-1:0] osteps_r, osteps_nxt;
  logic              oerr_r,   oerr_nxt;
  logic              olast_r,  olast_nxt;

  // RAM interface
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  logic [STEP_W-1:0] rd_step;
  logic [AW-1:0]     rd_pred;

  // candidate selection
  cand_t             cand;
  best_t             best;
  logic [AW-1:0]     best_pred;

  logic              in_acc;
  logic              out_acc;
  logic              req_err;
  logic              need_fill;
  logic              fill_done;
  logic              cur_last;

  mor_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_VALUE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mor_best u_best (
    .cand (cand),
    .best (best)
  );

  // read data; entry one is the base case and is never stored
  assign rd_step = rd_one_r ? '0 : ram_rdata[EW-1 -: STEP_W];
  assign rd_pred = ram_rdata[AW-1:0];

  // handshakes and request decode
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign req_err   = (in_target == '0) || (32'(in_target) >= 32'(MAX_VALUE));
  assign need_fill = CW'(in_target) >= CW'(next_v_r);
  assign fill_done = CW'(next_v_r) == CW'(target_r);
  assign cur_last  = (cur_r <= AW'(1)) || (cnt_r == CHAIN_LAST);

  // candidates for entry next_v
  assign cand.div3_ok   = (r3_r == 2'd0);
  assign cand.div2_ok   = ~next_v_r[0];
  assign cand.step_div3 = s3_r;
  assign cand.step_div2 = rd_step;
  assign cand.step_dec  = prev_step_r;

  always_comb begin
    case (best.pick)
      PICK_DIV3: best_pred = q3_r;
      PICK_DIV2: best_pred = AW'(next_v_r >> 1);
      PICK_DEC:  best_pred = AW'(next_v_r - NW'(1));
      default:   best_pred = AW'(next_v_r - NW'(1));
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (req_err) state_nxt = ST_EMIT;
          else if (need_fill) state_nxt = ST_FILL_RD3;
          else state_nxt = ST_TR_RD;
        end
      end
      ST_FILL_RD3: state_nxt = ST_FILL_RD2;
      ST_FILL_RD2: state_nxt = ST_FILL_WR;
      ST_FILL_WR: begin
        state_nxt = fill_done ? ST_TR_RD : ST_FILL_RD3;
      end
      ST_TR_RD:  state_nxt = ST_TR_CAP;
      ST_TR_CAP: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_acc) state_nxt = olast_r ? ST_IDLE : ST_TR_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = cur_r;
    case (state_r)
      ST_IDLE:     in_stall  = 1'b0;
      ST_FILL_RD3: ram_raddr = q3_r;
      ST_FILL_RD2: ram_raddr = AW'(next_v_r >> 1);
      ST_FILL_WR:  ram_we    = 1'b1;
      ST_TR_RD:    ram_raddr = cur_r;
      ST_TR_CAP:   ram_raddr = cur_r;
      ST_EMIT:     out_valid = 1'b1;
      default:     in_stall  = 1'b1;
    endcase
  end

  assign ram_waddr = AW'(next_v_r);
  assign ram_wdata = {best.step, best_pred};

  // datapath next values
  always_comb begin
    target_nxt    = target_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    steps_nxt     = steps_r;
    next_v_nxt    = next_v_r;
    q3_nxt        = q3_r;
    r3_nxt        = r3_r;
    prev_step_nxt = prev_step_r;
    s3_nxt        = s3_r;
    oval_nxt      = oval_r;
    osteps_nxt    = osteps_r;
    oerr_nxt      = oerr_r;
    olast_nxt     = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          target_nxt = in_target;
          cur_nxt    = AW'(in_target);
          cnt_nxt    = '0;
          first_nxt  = 1'b1;
          // rejected target: single error word
          oval_nxt   = '0;
          osteps_nxt = '0;
          oerr_nxt   = 1'b1;
          olast_nxt  = 1'b1;
        end
      end
      ST_FILL_RD2: s3_nxt = rd_step;
      ST_FILL_WR: begin
        prev_step_nxt = best.step;
        next_v_nxt    = next_v_r + NW'(1);
        if (r3_r == 2'd2) begin
          r3_nxt = 2'd0;
          q3_nxt = q3_r + AW'(1);
        end else begin
          r3_nxt = r3_r + 2'd1;
        end
      end
      ST_TR_CAP: begin
        oval_nxt   = VAL_W'(cur_r);
        osteps_nxt = first_r ? rd_step : steps_r;
        oerr_nxt   = 1'b0;
        olast_nxt  = cur_last;
        if (first_r) steps_nxt = rd_step;
        first_nxt  = 1'b0;
        cur_nxt    = rd_pred;
      end
      ST_EMIT: begin
        if (out_acc) cnt_nxt = cnt_r + CNT_W'(1);
      end
      default: begin
        target_nxt = target_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_v_r    <= NW'(2);
      q3_r        <= '0;
      r3_r        <= 2'd2;
      prev_step_r <= '0;
    end else begin
      state_r     <= state_nxt;
      next_v_r    <= next_v_nxt;
      q3_r        <= q3_nxt;
      r3_r        <= r3_nxt;
      prev_step_r <= prev_step_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    target_r <= target_nxt;
    cur_r    <= cur_nxt;
    cnt_r    <= cnt_nxt;
    first_r  <= first_nxt;
    steps_r  <= steps_nxt;
    s3_r     <= s3_nxt;
    rd_one_r <= (ram_raddr == AW'(1));
    oval_r   <= oval_nxt;
    osteps_r <= osteps_nxt;
    oerr_r   <= oerr_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_chain_value = oval_r;
  assign out_total_steps = osteps_r;
  assign out_error       = oerr_r;
  assign out_last        = olast_r;

endmodule
